// ----- rtl/core/tia_pkg.sv -----
// tia_pkg: shared types and constants of the triangle index assembler
// no dependencies; used by every file under rtl/core
`default_nettype none

package tia_pkg;

    localparam int VERTEX_W       = 16;  // running vertex counter
    localparam int ITOT_W         = 18;  // running index counter
    localparam int OUT_IDX_W      = 16;  // emitted index field
    localparam int INDEX_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;   // jobs between front and back

    typedef enum logic [2:0] {
        CMD_RESET  = 3'd0,
        CMD_BEGIN  = 3'd1,
        CMD_VERTEX = 3'd2,
        CMD_END    = 3'd3,
        CMD_ERROR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PRIM_TRI     = 2'd0,
        PRIM_STRIP   = 2'd1,
        PRIM_FAN     = 2'd2,
        PRIM_UNKNOWN = 2'd3
    } t_prim;

    typedef enum logic [1:0] {
        KIND_INDEX   = 2'd0,
        KIND_COMMIT  = 2'd1,
        KIND_DISCARD = 2'd2
    } t_kind;

    // one job = up to three results from one input item
    typedef struct packed {
        t_kind                kind;
        logic [1:0]           last_pos;     // position of the final result
        logic [VERTEX_W-1:0]  vertex_mark;
        logic [ITOT_W-1:0]    index_mark;
    } t_job_hdr;

    localparam int HDR_W = $bits(t_job_hdr);

endpackage

`default_nettype wire

// ----- rtl/core/tia_front.sv -----
// tia_front: group state and classification of incoming events into jobs
// depends on tia_pkg
`default_nettype none

module tia_front #(
    parameter int INDEX_BITS = tia_pkg::INDEX_BITS_DEF,
    localparam int IDX_W = (INDEX_BITS < tia_pkg::OUT_IDX_W) ? INDEX_BITS : tia_pkg::OUT_IDX_W
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_accept,
    input  wire [2:0]                i_cmd,
    input  wire [1:0]                i_prim_type,
    output logic                     o_job_valid,
    output tia_pkg::t_job_hdr        o_job_hdr,
    output logic [3*IDX_W-1:0]       o_job_idx
);

    tia_pkg::t_prim                  r_prim,    n_prim;
    logic [tia_pkg::VERTEX_W-1:0]    r_vtotal,  n_vtotal;
    logic [tia_pkg::ITOT_W-1:0]      r_itotal,  n_itotal;
    logic [tia_pkg::VERTEX_W-1:0]    r_gvstart, n_gvstart;
    logic [tia_pkg::ITOT_W-1:0]      r_gistart, n_gistart;
    logic [1:0]                      r_seen,    n_seen;
    logic                            r_odd,     n_odd;
    logic                            r_err,     n_err;

    logic [tia_pkg::VERTEX_W-1:0]    v_prev1, v_prev2;

    assign v_prev1 = r_vtotal - tia_pkg::VERTEX_W'(1);
    assign v_prev2 = r_vtotal - tia_pkg::VERTEX_W'(2);

    always_comb begin
        n_prim      = r_prim;
        n_vtotal    = r_vtotal;
        n_itotal    = r_itotal;
        n_gvstart   = r_gvstart;
        n_gistart   = r_gistart;
        n_seen      = r_seen;
        n_odd       = r_odd;
        n_err       = r_err;
        o_job_valid = 1'b0;
        o_job_hdr   = '0;
        o_job_idx   = '0;
        if (i_accept) begin
            unique case (tia_pkg::t_cmd'(i_cmd))
                tia_pkg::CMD_RESET: begin
                    n_prim    = tia_pkg::PRIM_TRI;
                    n_vtotal  = '0;
                    n_itotal  = '0;
                    n_gvstart = '0;
                    n_gistart = '0;
                    n_seen    = '0;
                    n_odd     = 1'b0;
                    n_err     = 1'b0;
                end
                tia_pkg::CMD_BEGIN: begin
                    n_prim = tia_pkg::t_prim'(i_prim_type);
                    n_seen = '0;
                    n_odd  = 1'b0;
                    if (tia_pkg::t_prim'(i_prim_type) == tia_pkg::PRIM_UNKNOWN) begin
                        n_err = 1'b1;
                    end
                end
                tia_pkg::CMD_VERTEX: begin
                    n_vtotal = r_vtotal + tia_pkg::VERTEX_W'(1);
                    if (!r_err) begin
                        if (r_prim == tia_pkg::PRIM_TRI) begin
                            o_job_valid        = 1'b1;
                            o_job_hdr.kind     = tia_pkg::KIND_INDEX;
                            o_job_hdr.last_pos = 2'd0;
                            o_job_idx[IDX_W-1:0] = r_vtotal[IDX_W-1:0];
                            n_itotal = r_itotal + tia_pkg::ITOT_W'(1);
                        end else if (r_prim == tia_pkg::PRIM_STRIP ||
                                     r_prim == tia_pkg::PRIM_FAN) begin
                            if (r_seen < 2'd2) begin
                                n_seen = r_seen + 2'd1;
                            end else begin
                                o_job_valid        = 1'b1;
                                o_job_hdr.kind     = tia_pkg::KIND_INDEX;
                                o_job_hdr.last_pos = 2'd2;
                                if (r_prim == tia_pkg::PRIM_FAN) begin
                                    o_job_idx[IDX_W-1:0]       = r_gvstart[IDX_W-1:0];
                                    o_job_idx[2*IDX_W-1:IDX_W] = v_prev1[IDX_W-1:0];
                                end else if (!r_odd) begin
                                    o_job_idx[IDX_W-1:0]       = v_prev2[IDX_W-1:0];
                                    o_job_idx[2*IDX_W-1:IDX_W] = v_prev1[IDX_W-1:0];
                                end else begin
                                    o_job_idx[IDX_W-1:0]       = v_prev1[IDX_W-1:0];
                                    o_job_idx[2*IDX_W-1:IDX_W] = v_prev2[IDX_W-1:0];
                                end
                                o_job_idx[3*IDX_W-1:2*IDX_W] = r_vtotal[IDX_W-1:0];
                                if (r_prim == tia_pkg::PRIM_STRIP) begin
                                    n_odd = !r_odd;
                                end
                                n_itotal = r_itotal + tia_pkg::ITOT_W'(3);
                            end
                        end
                    end
                end
                tia_pkg::CMD_END: begin
                    o_job_valid        = 1'b1;
                    o_job_hdr.last_pos = 2'd0;
                    if (r_err) begin
                        // roll back to the start of the group
                        n_vtotal              = r_gvstart;
                        n_itotal              = r_gistart;
                        n_err                 = 1'b0;
                        o_job_hdr.kind        = tia_pkg::KIND_DISCARD;
                        o_job_hdr.vertex_mark = r_gvstart;
                        o_job_hdr.index_mark  = r_gistart;
                    end else begin
                        n_gvstart             = r_vtotal;
                        n_gistart             = r_itotal;
                        o_job_hdr.kind        = tia_pkg::KIND_COMMIT;
                        o_job_hdr.vertex_mark = r_vtotal;
                        o_job_hdr.index_mark  = r_itotal;
                    end
                    n_seen = '0;
                    n_odd  = 1'b0;
                end
                tia_pkg::CMD_ERROR: begin
                    n_err = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim    <= tia_pkg::PRIM_TRI;
            r_vtotal  <= '0;
            r_itotal  <= '0;
            r_gvstart <= '0;
            r_gistart <= '0;
            r_seen    <= '0;
            r_odd     <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_prim    <= n_prim;
            r_vtotal  <= n_vtotal;
            r_itotal  <= n_itotal;
            r_gvstart <= n_gvstart;
            r_gistart <= n_gistart;
            r_seen    <= n_seen;
            r_odd     <= n_odd;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tia_queue.sv -----
// tia_queue: short register queue of jobs between front and back
// depends on tia_pkg for its default depth
`default_nettype none

module tia_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tia_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tia_back.sv -----
// tia_back: takes jobs from the queue and hands out one result per transfer
// depends on tia_pkg
`default_nettype none

module tia_back #(
    parameter int INDEX_BITS = tia_pkg::INDEX_BITS_DEF,
    localparam int IDX_W = (INDEX_BITS < tia_pkg::OUT_IDX_W) ? INDEX_BITS : tia_pkg::OUT_IDX_W
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_job_valid,
    input  tia_pkg::t_job_hdr                i_job_hdr,
    input  wire [3*IDX_W-1:0]                i_job_idx,
    output logic                             o_job_pop,
    input  wire                              i_pop,
    output logic                             o_empty,
    output logic [1:0]                       o_kind,
    output logic [tia_pkg::OUT_IDX_W-1:0]    o_index_value,
    output logic [tia_pkg::VERTEX_W-1:0]     o_vertex_mark,
    output logic [tia_pkg::ITOT_W-1:0]       o_index_mark,
    output logic                             o_last
);

    logic                r_valid, n_valid;
    logic [1:0]          r_pos,   n_pos;
    tia_pkg::t_job_hdr   r_hdr;
    logic [3*IDX_W-1:0]  r_idx;
    logic                at_last;
    logic                load;
    logic [IDX_W-1:0]    sel_idx;

    assign at_last   = (r_pos == r_hdr.last_pos);
    assign load      = !r_valid || (i_pop && at_last);
    assign o_job_pop = load && i_job_valid;

    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (load) begin
            n_valid = i_job_valid;
            n_pos   = '0;
        end else if (i_pop) begin
            n_pos = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_hdr <= i_job_hdr;
            r_idx <= i_job_idx;
        end
    end

    always_comb begin
        case (r_pos)
            2'd0:    sel_idx = r_idx[IDX_W-1:0];
            2'd1:    sel_idx = r_idx[2*IDX_W-1:IDX_W];
            default: sel_idx = r_idx[3*IDX_W-1:2*IDX_W];
        endcase
    end

    assign o_empty       = !r_valid;
    assign o_kind        = r_hdr.kind;
    assign o_index_value = tia_pkg::OUT_IDX_W'(sel_idx);
    assign o_vertex_mark = r_hdr.vertex_mark;
    assign o_index_mark  = r_hdr.index_mark;
    assign o_last        = at_last;

endmodule

`default_nettype wire

// ----- rtl/core/triangle_index_assembler_core.sv -----
// triangle_index_assembler_core: top level of the triangle index assembler
// depends on tia_pkg, tia_front, tia_queue and tia_back
//
// usage
//   input side is a queue write port: drive i_cmd / i_prim_type and raise push;
//   the event transfers on a rising edge where push is high and full is low
//   result side is a queue read port: while empty is low the oldest result sits
//   on o_kind, o_index_value, o_vertex_mark, o_index_mark, o_last; raise pop to
//   take it, the transfer happens on an edge where pop is high and empty is low
//   o_last marks the final result caused by one event
// timing
//   the front updates the group state and writes a job into a two-entry queue
//   at the edge that takes the event; when idle the back then loads the job
//   from the queue into its output register, where the first result shows
//   the back hands out one result per cycle while pop is high, so a strip or
//   fan vertex with a full triangle occupies it for three results, a list vertex
//   or end event for one; events that make no result occupy the front only
// stall and reset
//   while pop stays low the current result holds; the queue absorbs two more
//   jobs, then full rises and the front stops taking events
//   i_rst_n (synchronous, active low) clears the group state, the queue and
//   the output stage; the reset command clears only the group state
`default_nettype none

module triangle_index_assembler_core #(
    parameter int INDEX_BITS = tia_pkg::INDEX_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // event channel
    input  wire                              push,
    output logic                             full,
    input  wire [2:0]                        i_cmd,
    input  wire [1:0]                        i_prim_type,
    // result channel
    output logic                             empty,
    input  wire                              pop,
    output logic [1:0]                       o_kind,
    output logic [tia_pkg::OUT_IDX_W-1:0]    o_index_value,
    output logic [tia_pkg::VERTEX_W-1:0]     o_vertex_mark,
    output logic [tia_pkg::ITOT_W-1:0]       o_index_mark,
    output logic                             o_last
);

    // index width actually stored: the emitted field is never wider than 16
    localparam int IDX_W = (INDEX_BITS < tia_pkg::OUT_IDX_W) ? INDEX_BITS : tia_pkg::OUT_IDX_W;
    localparam int JOB_W = tia_pkg::HDR_W + 3 * IDX_W;

    logic                 accept;
    logic                 f_job_valid;
    tia_pkg::t_job_hdr    f_job_hdr;
    logic [3*IDX_W-1:0]   f_job_idx;

    logic                 q_valid;
    logic [JOB_W-1:0]     q_data;
    logic                 q_pop;

    assign accept = push && !full;

    // front: group bookkeeping, one event per cycle while full is low
    tia_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_prim_type (i_prim_type),
        .o_job_valid (f_job_valid),
        .o_job_hdr   (f_job_hdr),
        .o_job_idx   (f_job_idx)
    );

    // job queue decouples the front from a stalled result side
    tia_queue #(
        .WIDTH (JOB_W),
        .DEPTH (tia_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_job_valid),
        .i_data  ({f_job_hdr, f_job_idx}),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // back: serialises each job into results
    tia_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job_hdr     (tia_pkg::t_job_hdr'(q_data[JOB_W-1:3*IDX_W])),
        .i_job_idx     (q_data[3*IDX_W-1:0]),
        .o_job_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_index_value (o_index_value),
        .o_vertex_mark (o_vertex_mark),
        .o_index_mark  (o_index_mark),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tia_checker.sv -----
// tia_checker: port-level checks of triangle_index_assembler_core, bound in
// depends on tia_pkg and the top level's port list
`default_nettype none

module tia_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        empty,
    input wire        pop,
    input wire [1:0]  o_kind,
    input wire [15:0] o_index_value,
    input wire [15:0] o_vertex_mark,
    input wire [17:0] o_index_mark,
    input wire        o_last
);

    // a reset leaves nothing to read
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_index_value)
                              && $stable(o_vertex_mark) && $stable(o_index_mark)
                              && $stable(o_last)))
        else $error("stalled result changed");

    // group reports are single results
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != tia_pkg::KIND_INDEX) |-> (o_last && o_index_value == '0))
        else $error("group report not final or carries an index");

    // index results carry no marks
    a_index_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == tia_pkg::KIND_INDEX) |-> (o_vertex_mark == '0 && o_index_mark == '0))
        else $error("index result carries marks");

endmodule

bind triangle_index_assembler_core tia_checker u_tia_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_kind        (o_kind),
    .o_index_value (o_index_value),
    .o_vertex_mark (o_vertex_mark),
    .o_index_mark  (o_index_mark),
    .o_last        (o_last)
);

`default_nettype wire
